// File: hdl/ecc_pkg.sv
// Shared types, constants and microcode program of the Euler circuit checker.
`default_nettype none
package ecc_pkg;

    // Fixed field widths
    localparam int FUNC_W      = 1;
    localparam int VERTEX_W    = 7;
    localparam int STATUS_W    = 2;
    localparam int TOTAL_W     = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // Default sizes
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTED     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] VERTEX_COUNT_RST = 7'd64;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_EVAL = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EVAL   = 2'd3;

    // Datapath actions, one per control word
    typedef enum logic [3:0] {
        ACT_IDLE,   // take words, add edges
        ACT_NONE,
        ACT_INIT,   // clear counters and grew flag, set ok flags, seed vertex 1
        ACT_CLR,    // zero one balance entry
        ACT_ERD,    // read edge at edge counter
        ACT_RDA,    // read balance of edge start
        ACT_WRA,    // bump start balance, read end balance
        ACT_WRB,    // drop end balance, next edge
        ACT_WINIT,  // start a walk pass
        ACT_WALK,   // spread reach over one edge
        ACT_CINIT,  // start the vertex check
        ACT_BRD,    // read balance of checked vertex
        ACT_CHK,    // fold one vertex into the flags
        ACT_DONE    // hand the result to the output
    } act_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_EVAL,
        C_EDONE,
        C_VMORE,
        C_GREW,
        C_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Status from the datapath for the sequencer
    typedef struct packed {
        logic edone;
        logic vmore;
        logic grew;
    } dp_stat_t;

    typedef struct packed {
        dp_stat_t dp;
        logic     out_busy;
        logic     eval_acc;
    } seq_flags_t;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                eulerian;
        logic                connected;
        logic                degrees_ok;
        logic [TOTAL_W-1:0]  edge_total;
    } res_t;

    // Program step addresses
    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] STEP_INIT   = 4'd1;
    localparam logic [PC_W-1:0] STEP_CLR    = 4'd2;
    localparam logic [PC_W-1:0] STEP_DHEAD  = 4'd3;
    localparam logic [PC_W-1:0] STEP_DRDA   = 4'd4;
    localparam logic [PC_W-1:0] STEP_DWRA   = 4'd5;
    localparam logic [PC_W-1:0] STEP_DWRB   = 4'd6;
    localparam logic [PC_W-1:0] STEP_WINIT  = 4'd7;
    localparam logic [PC_W-1:0] STEP_WHEAD  = 4'd8;
    localparam logic [PC_W-1:0] STEP_WEVAL  = 4'd9;
    localparam logic [PC_W-1:0] STEP_WEND   = 4'd10;
    localparam logic [PC_W-1:0] STEP_CINIT  = 4'd11;
    localparam logic [PC_W-1:0] STEP_CRD    = 4'd12;
    localparam logic [PC_W-1:0] STEP_CEVAL  = 4'd13;
    localparam logic [PC_W-1:0] STEP_FINISH = 4'd14;
    localparam logic [PC_W-1:0] STEP_RETURN = 4'd15;

    function automatic ctrl_t cw(act_t a, cond_t c, logic [PC_W-1:0] t);
        ctrl_t w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Control store: jump to target when the condition holds, else step on
    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_IDLE:   w = cw(ACT_IDLE,  C_NO_EVAL,  STEP_IDLE);
            STEP_INIT:   w = cw(ACT_INIT,  C_NEVER,    STEP_IDLE);
            STEP_CLR:    w = cw(ACT_CLR,   C_VMORE,    STEP_CLR);
            STEP_DHEAD:  w = cw(ACT_ERD,   C_EDONE,    STEP_WINIT);
            STEP_DRDA:   w = cw(ACT_RDA,   C_NEVER,    STEP_IDLE);
            STEP_DWRA:   w = cw(ACT_WRA,   C_NEVER,    STEP_IDLE);
            STEP_DWRB:   w = cw(ACT_WRB,   C_ALWAYS,   STEP_DHEAD);
            STEP_WINIT:  w = cw(ACT_WINIT, C_NEVER,    STEP_IDLE);
            STEP_WHEAD:  w = cw(ACT_ERD,   C_EDONE,    STEP_WEND);
            STEP_WEVAL:  w = cw(ACT_WALK,  C_ALWAYS,   STEP_WHEAD);
            STEP_WEND:   w = cw(ACT_NONE,  C_GREW,     STEP_WINIT);
            STEP_CINIT:  w = cw(ACT_CINIT, C_NEVER,    STEP_IDLE);
            STEP_CRD:    w = cw(ACT_BRD,   C_NEVER,    STEP_IDLE);
            STEP_CEVAL:  w = cw(ACT_CHK,   C_VMORE,    STEP_CRD);
            STEP_FINISH: w = cw(ACT_DONE,  C_OUT_BUSY, STEP_FINISH);
            STEP_RETURN: w = cw(ACT_NONE,  C_ALWAYS,   STEP_IDLE);
            default:     w = cw(ACT_NONE,  C_ALWAYS,   STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: hdl/euler_circuit_check.sv
// Top level of the Euler circuit checker: ports, registers, output stage.
//
// Words on the s_ channel either add an edge (s_tuser = 0, vertices
// numbered from 1 in s_tdata) or ask for an evaluation (s_tuser = 1).
// Each word gives exactly one word on the m_ channel: the status in
// m_tuser and the flags and stored edge count in m_tdata.
// An add-edge word's result sits in the output register on the next
// cycle; edges load one per cycle while the receiver keeps up.
// An evaluation runs a microcoded program over the edge store and the
// balance store: it clears the balance entries, sums the balances over
// the stored edges, repeats reach passes until one adds no vertex (at
// most n passes for n vertices in use) and checks each vertex; the next
// word is taken only after the result is loaded and the program is idle.
// The user must write registers (directed, vertex_count) through the cfg
// port only while the block is idle; the block does not enforce it.
// Reset empties the edge store, sets the registers to undirected with 64
// vertices and drops any pending result. A stalled receiver holds the
// result; one more add-edge word is taken only once the output register
// is free or being taken.
`default_nettype none
module euler_circuit_check #(
    parameter int MAX_VERTICES = ecc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ecc_pkg::MAX_EDGES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_wen,
    input  wire logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [ecc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ecc_pkg::S_TDATA_W-1:0]  s_tdata,  // first_vertex, second_vertex
    input  wire logic                           s_tuser,  // func
    // result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ecc_pkg::M_TDATA_W-1:0]  m_tdata,  // eulerian, connected,
                                                          // degrees_ok, edge_total
    output logic      [ecc_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import ecc_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);

    logic                  directed_reg;
    logic [CFG_DATA_W-1:0] vcount_reg;
    logic [VCW-1:0]        n_active;

    logic                  m_valid_reg;
    res_t                  res_reg;

    ctrl_t                 ctrl;
    seq_flags_t            flags;
    dp_stat_t              dp_stat;
    res_t                  res;
    logic                  out_busy, accept, add_req, load;
    logic [VERTEX_W-1:0]   first_vertex, second_vertex;

    assign first_vertex  = s_tdata[VERTEX_W-1:0];
    assign second_vertex = s_tdata[2*VERTEX_W-1:VERTEX_W];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            directed_reg <= 1'b0;
            vcount_reg   <= VERTEX_COUNT_RST;
        end else if (cfg_wen) begin
            case (cfg_idx)
                REG_DIRECTED:     directed_reg <= cfg_wdata[0];
                REG_VERTEX_COUNT: vcount_reg   <= cfg_wdata;
                default:          directed_reg <= directed_reg;
            endcase
        end
    end

    // vertices in use: zero acts as one, clipped to the store size
    always_comb begin
        if (vcount_reg == '0) begin
            n_active = VCW'(1);
        end else if (32'(vcount_reg) > MAX_VERTICES) begin
            n_active = VCW'(MAX_VERTICES);
        end else begin
            n_active = VCW'(vcount_reg);
        end
    end

    // handshakes
    assign out_busy = m_valid_reg && !m_tready;
    assign s_tready = (ctrl.act == ACT_IDLE) && !out_busy;
    assign accept   = s_tvalid && s_tready;
    assign add_req  = accept && (s_tuser == FUNC_ADD);
    assign load     = add_req || ((ctrl.act == ACT_DONE) && !out_busy);

    assign flags.dp       = dp_stat;
    assign flags.out_busy = out_busy;
    assign flags.eval_acc = accept && (s_tuser == FUNC_EVAL);

    ecc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    ecc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VCW          (VCW)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .act           (ctrl.act),
        .add_req       (add_req),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .directed      (directed_reg),
        .n_active      (n_active),
        .stat          (dp_stat),
        .res           (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = M_TDATA_W'({res_reg.edge_total, res_reg.degrees_ok,
                                  res_reg.connected, res_reg.eulerian});

endmodule
`default_nettype wire

// File: hdl/ecc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ecc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, read port returns old data on a collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/ecc_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module ecc_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ecc_pkg::seq_flags_t flags,
    output ecc_pkg::ctrl_t           ctrl
);
    import ecc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = ucode(pc_reg);

    // condition select
    always_comb begin
        case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_EVAL:  take = !flags.eval_acc;
            C_EDONE:    take = flags.dp.edone;
            C_VMORE:    take = flags.dp.vmore;
            C_GREW:     take = flags.dp.grew;
            C_OUT_BUSY: take = flags.out_busy;
            default:    take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ecc_datapath.sv
// Datapath: edge store, balance store, reach set, counters and result flags.
`default_nettype none
module ecc_datapath #(
    parameter int MAX_VERTICES = ecc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ecc_pkg::MAX_EDGES_DEF,
    parameter int VCW          = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ecc_pkg::act_t                act,
    input  wire logic                         add_req,
    input  wire logic [ecc_pkg::VERTEX_W-1:0] first_vertex,
    input  wire logic [ecc_pkg::VERTEX_W-1:0] second_vertex,
    input  wire logic                         directed,
    input  wire logic [VCW-1:0]               n_active,
    output ecc_pkg::dp_stat_t                 stat,
    output ecc_pkg::res_t                     res
);
    import ecc_pkg::*;

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int BW  = EW + 1;

    logic [EW-1:0]           stored_reg;
    logic [EW-1:0]           ecnt_reg;
    logic [VW-1:0]           vcnt_reg;
    logic [MAX_VERTICES-1:0] reached_reg;
    logic                    grew_reg;
    logic                    deg_ok_reg;
    logic                    conn_ok_reg;

    logic [2*VW-1:0] edge_rd;
    logic [VW-1:0]   ea, eb;
    logic            e_in, e_use, ra, rb;
    logic            bad, full, add_ok;
    logic            edge_re;

    logic            bal_we, bal_re;
    logic [VW-1:0]   bal_waddr, bal_raddr;
    logic [BW-1:0]   bal_wdata, bal_rd;
    logic            vert_ok;
    res_t            add_res, eval_res;

    // add-edge checks
    assign bad = (first_vertex == '0) || (second_vertex == '0)
              || (32'(first_vertex) > 32'(n_active))
              || (32'(second_vertex) > 32'(n_active));
    assign full   = (32'(stored_reg) == MAX_EDGES);
    assign add_ok = add_req && !bad && !full;

    // edge store: start vertex low, end vertex high, both 0-based
    assign edge_re = (act == ACT_ERD) && !stat.edone;

    ecc_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_ram (
        .aclk  (aclk),
        .we    (add_ok),
        .waddr (stored_reg[EAW-1:0]),
        .wdata ({VW'(second_vertex - 7'd1), VW'(first_vertex - 7'd1)}),
        .re    (edge_re),
        .raddr (ecnt_reg[EAW-1:0]),
        .rdata (edge_rd)
    );

    assign ea    = edge_rd[VW-1:0];
    assign eb    = edge_rd[2*VW-1:VW];
    assign e_in  = (VCW'(ea) < n_active) && (VCW'(eb) < n_active);
    assign e_use = e_in && (ea != eb);
    assign ra    = reached_reg[ea];
    assign rb    = reached_reg[eb];

    // balance store: out minus in per vertex; self-loops leave it alone
    always_comb begin
        bal_we    = 1'b0;
        bal_waddr = vcnt_reg;
        bal_wdata = '0;
        bal_re    = 1'b0;
        bal_raddr = vcnt_reg;
        case (act)
            ACT_CLR: begin
                bal_we = 1'b1;
            end
            ACT_RDA: begin
                bal_re    = 1'b1;
                bal_raddr = ea;
            end
            ACT_WRA: begin
                bal_we    = e_use;
                bal_waddr = ea;
                bal_wdata = bal_rd + 1'b1;
                bal_re    = 1'b1;
                bal_raddr = eb;
            end
            ACT_WRB: begin
                bal_we    = e_use;
                bal_waddr = eb;
                bal_wdata = bal_rd - 1'b1;
            end
            ACT_BRD: begin
                bal_re = 1'b1;
            end
            default: begin
                bal_we = 1'b0;
            end
        endcase
    end

    ecc_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_bal_ram (
        .aclk  (aclk),
        .we    (bal_we),
        .waddr (bal_waddr),
        .wdata (bal_wdata),
        .re    (bal_re),
        .raddr (bal_raddr),
        .rdata (bal_rd)
    );

    // directed: balanced; undirected: even degree is even balance
    assign vert_ok = directed ? (bal_rd == '0) : !bal_rd[0];

    // counters, reach set and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg  <= '0;
            ecnt_reg    <= '0;
            vcnt_reg    <= '0;
            grew_reg    <= 1'b0;
            deg_ok_reg  <= 1'b0;
            conn_ok_reg <= 1'b0;
        end else begin
            case (act)
                ACT_IDLE: begin
                    if (add_ok) begin
                        stored_reg <= stored_reg + 1'b1;
                    end
                end
                ACT_INIT: begin
                    ecnt_reg    <= '0;
                    vcnt_reg    <= '0;
                    reached_reg <= MAX_VERTICES'(1);
                    grew_reg    <= 1'b0;
                    deg_ok_reg  <= 1'b1;
                    conn_ok_reg <= 1'b1;
                end
                ACT_CLR: begin
                    vcnt_reg <= vcnt_reg + 1'b1;
                end
                ACT_WRB: begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                end
                ACT_WINIT: begin
                    ecnt_reg <= '0;
                    grew_reg <= 1'b0;
                end
                ACT_WALK: begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    if (e_in && ra && !rb) begin
                        reached_reg[eb] <= 1'b1;
                        grew_reg        <= 1'b1;
                    end
                    if (e_in && !directed && rb && !ra) begin
                        reached_reg[ea] <= 1'b1;
                        grew_reg        <= 1'b1;
                    end
                end
                ACT_CINIT: begin
                    vcnt_reg <= '0;
                end
                ACT_CHK: begin
                    vcnt_reg    <= vcnt_reg + 1'b1;
                    deg_ok_reg  <= deg_ok_reg && vert_ok;
                    conn_ok_reg <= conn_ok_reg && reached_reg[vcnt_reg];
                end
                default: begin
                    grew_reg <= grew_reg;
                end
            endcase
        end
    end

    // status for the sequencer
    assign stat.edone = (ecnt_reg == stored_reg);
    assign stat.vmore = (VCW'(vcnt_reg) != n_active - 1'b1);
    assign stat.grew  = grew_reg;

    // result words
    always_comb begin
        add_res.status     = bad ? STAT_BAD : (full ? STAT_FULL : STAT_STORED);
        add_res.eulerian   = 1'b0;
        add_res.connected  = 1'b0;
        add_res.degrees_ok = 1'b0;
        add_res.edge_total = add_ok ? TOTAL_W'(stored_reg + 1'b1) : TOTAL_W'(stored_reg);

        eval_res.status     = STAT_EVAL;
        eval_res.eulerian   = conn_ok_reg && deg_ok_reg;
        eval_res.connected  = conn_ok_reg;
        eval_res.degrees_ok = deg_ok_reg;
        eval_res.edge_total = TOTAL_W'(stored_reg);
    end

    assign res = (act == ACT_DONE) ? eval_res : add_res;

endmodule
`default_nettype wire

// File: bench/euler_result_monitor.sv
// Result monitor for the Euler circuit checker: graph predictor and word-by-word compare.
module euler_result_monitor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ecc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ecc_pkg::S_TDATA_W-1:0]  s_tdata,  // first_vertex, second_vertex
    input  logic                           s_tuser,  // func
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ecc_pkg::M_TDATA_W-1:0]  m_tdata,  // eulerian, connected, degrees_ok,
                                                     // edge_total
    input  logic [ecc_pkg::STATUS_W-1:0]   m_tuser,  // status
    output int                             mismatches,
    output int                             pending
);
    import ecc_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int NE = MAX_EDGES_DEF;

    // Shadow of the graph: 0-based vertex pairs in arrival order
    logic [VERTEX_W-1:0] edge_src [NE];
    logic [VERTEX_W-1:0] edge_dst [NE];
    int unsigned         edge_cnt;
    logic                directed_mode;
    logic [CFG_DATA_W-1:0] vcount;

    res_t expected_results [$];
    int   err_cnt = 0;
    int   pend_r  = 0;

    assign mismatches = err_cnt;
    assign pending    = pend_r;

    // Apply one input word to the shadow graph and work out its result word
    task automatic predict_result(input logic fn, input logic [VERTEX_W-1:0] u,
                                  input logic [VERTEX_W-1:0] v, output res_t r);
        int unsigned   n;
        logic [NV-1:0] reach;
        bit            grew;
        bit            conn;
        bit            degs;
        int            out_d [NV];
        int            in_d [NV];
        int            a;
        int            b;
        begin
            n = (vcount == 0) ? 1 : (vcount > NV) ? NV : vcount;
            r = '0;
            if (fn == FUNC_EVAL) begin
                // reach closure from vertex 1; edges touching unused vertices are skipped
                reach = '0;
                reach[0] = 1'b1;
                grew = 1'b1;
                while (grew) begin
                    grew = 1'b0;
                    for (int e = 0; e < edge_cnt; e++) begin
                        a = int'(edge_src[e]);
                        b = int'(edge_dst[e]);
                        if (a < n && b < n) begin
                            if (reach[a] && !reach[b]) begin
                                reach[b] = 1'b1;
                                grew = 1'b1;
                            end
                            if (!directed_mode && reach[b] && !reach[a]) begin
                                reach[a] = 1'b1;
                                grew = 1'b1;
                            end
                        end
                    end
                end
                conn = 1'b1;
                for (int i = 0; i < n; i++)
                    if (!reach[i]) conn = 1'b0;

                // degree balance over in-use edges; a self-loop adds to both counts
                for (int i = 0; i < NV; i++) begin
                    out_d[i] = 0;
                    in_d[i] = 0;
                end
                for (int e = 0; e < edge_cnt; e++) begin
                    a = int'(edge_src[e]);
                    b = int'(edge_dst[e]);
                    if (a < n && b < n) begin
                        out_d[a]++;
                        in_d[b]++;
                    end
                end
                degs = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (directed_mode) begin
                        if (out_d[i] != in_d[i]) degs = 1'b0;
                    end else begin
                        if ((out_d[i] + in_d[i]) % 2 != 0) degs = 1'b0;
                    end
                end
                r.status     = STAT_EVAL;
                r.connected  = conn;
                r.degrees_ok = degs;
                r.eulerian   = conn && degs;
            end else if (u == 0 || v == 0 || u > n || v > n) begin
                r.status = STAT_BAD;
            end else if (edge_cnt >= NE) begin
                r.status = STAT_FULL;
            end else begin
                edge_src[edge_cnt] = u - 1'b1;
                edge_dst[edge_cnt] = v - 1'b1;
                edge_cnt++;
                r.status = STAT_STORED;
            end
            r.edge_total = TOTAL_W'(edge_cnt);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
                err_cnt++;
            end
        end
    endtask

    // Sample both channels and the register port at every edge
    always @(posedge aclk) begin
        res_t want;
        res_t fresh;
        if (!aresetn) begin
            edge_cnt = 0;
            directed_mode = 1'b0;
            vcount = VERTEX_COUNT_RST;
            expected_results.delete();
            pend_r <= 0;
        end else begin
            if (cfg_wen) begin
                if (cfg_idx == REG_DIRECTED) directed_mode = cfg_wdata[0];
                else if (cfg_idx == REG_VERTEX_COUNT) vcount = cfg_wdata;
            end

            // result word: compare against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none got status %0d",
                             $time, m_tuser);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("eulerian", 32'(want.eulerian), 32'(m_tdata[0]));
                    check_field("connected", 32'(want.connected), 32'(m_tdata[1]));
                    check_field("degrees_ok", 32'(want.degrees_ok), 32'(m_tdata[2]));
                    check_field("edge_total", 32'(want.edge_total),
                                32'(m_tdata[3 +: TOTAL_W]));
                end
            end

            // input word: predict its result and queue it behind the others
            if (s_tvalid && s_tready) begin
                predict_result(s_tuser, s_tdata[0 +: VERTEX_W],
                               s_tdata[VERTEX_W +: VERTEX_W], fresh);
                expected_results = {expected_results, fresh};
            end
            pend_r <= expected_results.size();
        end
    end

endmodule

// File: bench/tb_euler_circuit_check.sv
// Testbench top for the Euler circuit checker: clock, reset, stimulus and verdict.
module tb_euler_circuit_check;
    import ecc_pkg::*;

    localparam int QUIET_LIMIT = 250000;
    localparam int PHASE_WORDS = 28;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int words_sent = 0;
    int quiet      = 0;
    int mismatches;
    int pending;

    euler_circuit_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    euler_result_monitor monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one input word, with random sender gaps ahead of it
    task automatic put_word(input logic fn, input logic [VERTEX_W-1:0] a,
                            input logic [VERTEX_W-1:0] b);
        begin
            while ($urandom_range(0, 99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= fn;
            s_tdata  <= {2'b00, b, a};
            do @(posedge aclk); while (!s_tready);
            words_sent++;
        end
    endtask

    // hold off until every result word has come back
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (pending != 0) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        begin
            cfg_wen   <= 1'b1;
            cfg_idx   <= idx;
            cfg_wdata <= val;
            @(posedge aclk);
            cfg_wen <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // closed walk through vertices 1..n in random order; broken walks lose
    // one edge or gain a stray one
    task automatic send_circuit(input int n, input bit broken);
        int order [64];
        int j;
        int tmp;
        int skip;
        int x;
        int y;
        int z;
        begin
            for (int i = 0; i < n; i++) order[i] = i + 1;
            for (int i = n - 1; i >= 2; i--) begin
                j = $urandom_range(1, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            skip = -1;
            if (broken && $urandom_range(0, 1)) skip = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
                if (i != skip)
                    put_word(FUNC_ADD, VERTEX_W'(order[i]), VERTEX_W'(order[(i + 1) % n]));
            if (broken && skip < 0)
                put_word(FUNC_ADD, VERTEX_W'($urandom_range(1, n)),
                         VERTEX_W'($urandom_range(1, n)));
            // extra small loop keeps the balance but raises degrees
            if ($urandom_range(0, 9) < 3) begin
                x = $urandom_range(1, n);
                y = $urandom_range(1, n);
                z = $urandom_range(1, n);
                put_word(FUNC_ADD, VERTEX_W'(x), VERTEX_W'(y));
                put_word(FUNC_ADD, VERTEX_W'(y), VERTEX_W'(z));
                put_word(FUNC_ADD, VERTEX_W'(z), VERTEX_W'(x));
            end
        end
    endtask

    // scattered edges, some with vertex numbers out of range
    task automatic send_noise(input int n);
        int k;
        begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 3) == 0)
                    put_word(FUNC_ADD, VERTEX_W'($urandom_range(0, 127)),
                             VERTEX_W'($urandom_range(0, 127)));
                else
                    put_word(FUNC_ADD, VERTEX_W'($urandom_range(1, n)),
                             VERTEX_W'($urandom_range(1, n)));
            end
        end
    endtask

    initial begin
        int vc_pick [12];
        int vc;
        int eff;
        int start;
        int r;
        vc_pick = '{3, 5, 0, 8, 2, 6, 1, 4, 10, 127, 7, 64};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // fixed part, undirected then directed: empty graph, bad vertices, self-loops, count extremes
        put_word(FUNC_EVAL, 7'd0, 7'd0);
        drain();
        write_reg(REG_VERTEX_COUNT, 7'd1);
        put_word(FUNC_ADD, 7'd0, 7'd1);
        put_word(FUNC_ADD, 7'd1, 7'd0);
        put_word(FUNC_ADD, 7'd2, 7'd1);
        put_word(FUNC_ADD, 7'd127, 7'd127);
        put_word(FUNC_ADD, 7'd1, 7'd1);
        put_word(FUNC_EVAL, 7'd0, 7'd0);
        drain();
        write_reg(REG_VERTEX_COUNT, 7'd0);
        put_word(FUNC_ADD, 7'd2, 7'd2);
        put_word(FUNC_ADD, 7'd1, 7'd1);
        put_word(FUNC_EVAL, 7'd127, 7'd127);
        drain();
        write_reg(REG_VERTEX_COUNT, 7'd127);
        put_word(FUNC_ADD, 7'd64, 7'd64);
        put_word(FUNC_ADD, 7'd64, 7'd1);
        put_word(FUNC_ADD, 7'd65, 7'd1);
        put_word(FUNC_EVAL, 7'd85, 7'd42);
        drain();
        write_reg(REG_DIRECTED, 7'd1);
        write_reg(REG_VERTEX_COUNT, 7'd3);
        put_word(FUNC_ADD, 7'd1, 7'd2);
        put_word(FUNC_ADD, 7'd2, 7'd3);
        put_word(FUNC_ADD, 7'd3, 7'd1);
        put_word(FUNC_EVAL, 7'd0, 7'd0);
        put_word(FUNC_ADD, 7'd3, 7'd2);
        put_word(FUNC_EVAL, 7'd0, 7'd0);

        // random phases: register settings change between phases, idling and stalls per phase
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            vc = vc_pick[ph];
            eff = (vc == 0) ? 1 : (vc > 64) ? 64 : vc;
            write_reg(REG_DIRECTED, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(vc));
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_circuit(eff, 1'b0);
                else if (r < 8)
                    send_circuit(eff, 1'b1);
                else
                    send_noise(eff);
                put_word(FUNC_EVAL, VERTEX_W'($urandom_range(0, 127)),
                         VERTEX_W'($urandom_range(0, 127)));
            end
        end

        // let the last results come home
        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: euler_circuit_check.f
hdl/ecc_pkg.sv
hdl/ecc_ram.sv
hdl/ecc_seq.sv
hdl/ecc_datapath.sv
hdl/euler_circuit_check.sv
bench/euler_result_monitor.sv
bench/tb_euler_circuit_check.sv
